/* src/cd_pkg.sv */
// Shared types and constants for the circular deque.
`default_nettype none
package cd_pkg;

   localparam int DEPTH_DEF = 8;
   localparam int MODE_W    = 2;
   localparam int DATA_W    = 32;
   localparam int STAT_W    = 2;
   localparam int OCC_W     = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_REAR  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_REAR   = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE      = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       push_front;
      logic       push_rear;
      logic       pop_front;
      logic       pop_rear;
      logic       ld_rsp;
      status_type status;
      logic       ld_pop_value;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic full;
   } flag_type;

endpackage
`default_nettype wire

/* src/cd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* src/cd_ctrl.sv */
// Request sequencing state machine for the circular deque.
`default_nettype none
module cd_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [cd_pkg::MODE_W-1:0]   req_mode,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire cd_pkg::flag_type            flags,
   output cd_pkg::cmd_type                  cmd
);
   import cd_pkg::*;

   state_type state_ff;
   state_type state_in;
   mode_type  mode;

   assign mode = mode_type'(req_mode);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if ((mode == MODE_POP_FRONT || mode == MODE_POP_REAR) && !flags.empty) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.ld_rsp = 1'b1;
               cmd.status = ST_DONE;
               unique case (mode)
                  MODE_PUSH_FRONT: begin
                     if (flags.full) cmd.status = ST_OVERFLOW;
                     else            cmd.push_front = 1'b1;
                  end
                  MODE_PUSH_REAR: begin
                     if (flags.full) cmd.status = ST_OVERFLOW;
                     else            cmd.push_rear = 1'b1;
                  end
                  MODE_POP_FRONT: begin
                     if (flags.empty) cmd.status = ST_UNDERFLOW;
                     else             cmd.pop_front = 1'b1;
                  end
                  MODE_POP_REAR: begin
                     if (flags.empty) cmd.status = ST_UNDERFLOW;
                     else             cmd.pop_rear = 1'b1;
                  end
                  default: begin
                     cmd.status = ST_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.ld_pop_value = 1'b1;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // the popped word is loaded in the cycle before the response is shown
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_RESP))
      else $error("read stage not followed by response");

   // a request is only taken while no response is outstanding
   assert property (@(posedge clock) disable iff (reset)
      (req_ready && rsp_valid) == 1'b0)
      else $error("request taken with response pending");

   // a stalled response keeps the controller in place
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule
`default_nettype wire

/* src/cd_datapath.sv */
// Index, count, slot store and response registers of the circular deque.
`default_nettype none
module cd_datapath #(
   parameter int DEPTH = cd_pkg::DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cd_pkg::cmd_type                   cmd,
   output cd_pkg::flag_type                       flags,
   input  wire logic signed [cd_pkg::DATA_W-1:0]  req_value_in,
   output logic        [cd_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [cd_pkg::DATA_W-1:0]       rsp_value_out,
   output logic        [cd_pkg::OCC_W-1:0]        rsp_occupancy
);
   import cd_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [STAT_W-1:0] status_ff;
   logic [DATA_W-1:0] value_ff;
   logic [OCC_W-1:0]  occ_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic [IDX_W-1:0]  head_next, head_prev, tail_next, tail_prev;

   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;

   assign flags.empty = (cnt_ff == '0);
   assign flags.full  = (cnt_ff == CNT_W'(DEPTH));

   assign wr_en   = cmd.push_front | cmd.push_rear;
   assign rd_en   = cmd.pop_front | cmd.pop_rear;
   assign rd_addr = cmd.pop_front ? head_ff : tail_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      wr_addr = '0;
      if (wr_en) begin
         cnt_in = cnt_ff + 1'b1;
         priority if (flags.empty) begin
            // first element always lands in slot zero
            head_in = '0;
            tail_in = '0;
            wr_addr = '0;
         end else if (cmd.push_front) begin
            head_in = head_prev;
            wr_addr = head_prev;
         end else begin
            tail_in = tail_next;
            wr_addr = tail_next;
         end
      end else if (rd_en) begin
         cnt_in = cnt_ff - 1'b1;
         priority if (cnt_ff == CNT_W'(1)) begin
            head_in = '0;
            tail_in = '0;
         end else if (cmd.pop_front) begin
            head_in = head_next;
         end else begin
            tail_in = tail_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_rsp) begin
         status_ff <= cmd.status;
         value_ff  <= '0;
         occ_ff    <= OCC_W'(cnt_in);
      end else if (cmd.ld_pop_value) begin
         value_ff  <= rd_data;
      end
   end

   cd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_status    = status_ff;
   assign rsp_value_out = value_ff;
   assign rsp_occupancy = occ_ff;

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("element count beyond store depth");

   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("indices not parked while empty");

   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == CNT_W'(1)) |-> (head_ff == tail_ff))
      else $error("single element but front and rear differ");

   assert property (@(posedge clock) disable iff (reset)
      !(wr_en && flags.full) && !(rd_en && flags.empty) && !(wr_en && rd_en))
      else $error("illegal store access issued");

   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("push did not grow the count");

endmodule
`default_nettype wire

/* src/circular_deque.sv */
// Circular deque: top level joining the controller and the datapath.
//
// Double-ended queue of DEPTH signed 32-bit words in a circular slot RAM.
// Request channel (req_valid/req_ready): req_mode selects push front, push
// rear, pop front or pop rear; req_value_in is the word to push.
// Response channel (rsp_valid/rsp_ready): one response per request with
// rsp_status (done, overflow, underflow), rsp_value_out (popped word, else
// zero) and rsp_occupancy (elements held afterwards, low four bits).
// A push or a refused request shows its response the cycle after it is
// taken; a successful pop passes through a read state first, since the
// slot RAM has a registered read port. Only one request is handled at a
// time; a new request is taken the cycle after the response is taken.
// Reset empties the deque and parks both indices at slot zero; slot
// contents are not cleared. While the receiver stalls the response is held
// and no further request is taken.
`default_nettype none
module circular_deque #(
   parameter int DEPTH = cd_pkg::DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic        [cd_pkg::MODE_W-1:0]  req_mode,
   input  wire logic signed [cd_pkg::DATA_W-1:0]  req_value_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic        [cd_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [cd_pkg::DATA_W-1:0]       rsp_value_out,
   output logic        [cd_pkg::OCC_W-1:0]        rsp_occupancy
);
   import cd_pkg::*;

   cmd_type  cmd;
   flag_type flags;

   cd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   cd_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .flags         (flags),
      .req_value_in  (req_value_in),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule
`default_nettype wire

/* tb/deque_checker.sv */
// Checker for the circular deque: predicts every response and compares it.
`timescale 1ns / 1ps
module deque_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic        [cd_pkg::MODE_W-1:0]  req_mode,
   input  wire logic signed [cd_pkg::DATA_W-1:0]  req_value_in,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic        [cd_pkg::STAT_W-1:0]  rsp_status,
   input  wire logic signed [cd_pkg::DATA_W-1:0]  rsp_value_out,
   input  wire logic        [cd_pkg::OCC_W-1:0]   rsp_occupancy,
   output int                                     fail_count,
   output int                                     pending_count
);
   import cd_pkg::*;

   localparam int DEPTH = DEPTH_DEF;

   typedef struct {
      status_type                status;
      logic signed [DATA_W-1:0]  value;
      logic        [OCC_W-1:0]   occupancy;
   } deque_reply_type;

   // shadow copy of the deque
   logic signed [DATA_W-1:0] mirror_slot [DEPTH];
   int                       mirror_head;
   int                       mirror_tail;
   logic                     mirror_empty;

   deque_reply_type awaited_rsp [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic deque_reply_type apply_deque_op(mode_type op, logic signed [DATA_W-1:0] v);
      deque_reply_type r;
      int              held;
      r.status = ST_DONE;
      r.value  = '0;
      if (op == MODE_PUSH_FRONT || op == MODE_PUSH_REAR) begin
         if (mirror_empty) begin
            // first element always lands in slot zero
            mirror_head    = 0;
            mirror_tail    = 0;
            mirror_slot[0] = v;
            mirror_empty   = 1'b0;
         end else if ((mirror_tail + 1) % DEPTH == mirror_head) begin
            r.status = ST_OVERFLOW;
         end else if (op == MODE_PUSH_FRONT) begin
            mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
            mirror_slot[mirror_head] = v;
         end else begin
            mirror_tail = (mirror_tail + 1) % DEPTH;
            mirror_slot[mirror_tail] = v;
         end
      end else begin
         if (mirror_empty) begin
            r.status = ST_UNDERFLOW;
         end else if (mirror_head == mirror_tail) begin
            r.value      = mirror_slot[mirror_head];
            mirror_head  = 0;
            mirror_tail  = 0;
            mirror_empty = 1'b1;
         end else if (op == MODE_POP_FRONT) begin
            r.value     = mirror_slot[mirror_head];
            mirror_head = (mirror_head + 1) % DEPTH;
         end else begin
            r.value     = mirror_slot[mirror_tail];
            mirror_tail = (mirror_tail + DEPTH - 1) % DEPTH;
         end
      end
      held = mirror_empty ? 0 : (mirror_tail + DEPTH - mirror_head) % DEPTH + 1;
      r.occupancy = held[OCC_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      deque_reply_type want;
      int              errs;
      errs = 0;
      if (reset) begin
         mirror_head  = 0;
         mirror_tail  = 0;
         mirror_empty = 1'b1;
         awaited_rsp.delete();
      end else begin
         // response first: a request taken this edge cannot be answered yet
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("response with no request outstanding: status %0d value %0d occ %0d",
                      rsp_status, rsp_value_out, rsp_occupancy);
               errs++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  errs++;
               end
               if (rsp_value_out !== want.value) begin
                  $error("rsp_value_out: expected %0d, got %0d", want.value, rsp_value_out);
                  errs++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $error("rsp_occupancy: expected %0d, got %0d",
                         want.occupancy, rsp_occupancy);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready)
            awaited_rsp.push_back(apply_deque_op(mode_type'(req_mode), req_value_in));
      end
      fail_count    <= fail_count + errs;
      pending_count <= awaited_rsp.size();
   end

endmodule

/* tb/tb_circular_deque.sv */
// Top of the circular deque testbench: clock, reset, requests and verdict.
`timescale 1ns / 1ps
module tb_circular_deque;
   import cd_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic        [MODE_W-1:0] req_mode = MODE_PUSH_FRONT;
   logic signed [DATA_W-1:0] req_value_in = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic        [STAT_W-1:0] rsp_status;
   logic signed [DATA_W-1:0] rsp_value_out;
   logic        [OCC_W-1:0]  rsp_occupancy;
   int                       fail_count;
   int                       pending_count;
   int                       cycle_count = 0;
   int                       stall_tick = 0;
   int                       stall_style = 0;

   always #5 clock = ~clock;

   circular_deque DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_occupancy (rsp_occupancy)
   );

   deque_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_occupancy (rsp_occupancy),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // receiver: rsp_ready follows one of four stall styles, redrawn at random
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 0)
         stall_style <= $urandom_range(0, 3);
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) != 0);
         default: rsp_ready <= (stall_tick % 8 < 4);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_circular_deque failed");
         $finish;
      end
   end

   task automatic issue(mode_type op, logic signed [DATA_W-1:0] v);
      req_valid    <= 1'b1;
      req_mode     <= op;
      req_value_in <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic await_drain();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0: return MAX_VAL;
         1: return MIN_VAL;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      int sent;
      int burst_left;
      int push_pct;
      int gap;
      mode_type op;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty deque: both pops underflow
      issue(MODE_POP_FRONT, 32'sh1234_5678);
      issue(MODE_POP_REAR, MIN_VAL);
      // push into empty, then pop of the last element
      issue(MODE_PUSH_FRONT, MAX_VAL);
      issue(MODE_POP_REAR, '0);
      issue(MODE_PUSH_REAR, MIN_VAL);
      issue(MODE_PUSH_FRONT, -1);
      // fill to capacity with head wrapped below slot zero
      issue(MODE_PUSH_REAR, '0);
      issue(MODE_PUSH_REAR, 32'sh5555_5555);
      issue(MODE_PUSH_FRONT, 32'shaaaa_aaaa);
      issue(MODE_PUSH_REAR, 1);
      issue(MODE_PUSH_FRONT, -2);
      issue(MODE_PUSH_REAR, MAX_VAL);
      // full: both pushes overflow
      issue(MODE_PUSH_FRONT, 32'sh0f0f_0f0f);
      issue(MODE_PUSH_REAR, 32'shf0f0_f0f0);
      issue(MODE_POP_FRONT, '0);
      issue(MODE_POP_REAR, '0);
      issue(MODE_PUSH_REAR, 32'sh0000_ffff);
      issue(MODE_POP_FRONT, '0);
      issue(MODE_POP_FRONT, '0);
      issue(MODE_POP_REAR, '0);
      issue(MODE_POP_FRONT, '0);
      issue(MODE_POP_REAR, '0);
      issue(MODE_POP_FRONT, '0);
      issue(MODE_POP_REAR, '0);
      issue(MODE_POP_FRONT, '0);
      req_valid <= 1'b0;
      await_drain();

      sent       = 0;
      burst_left = 0;
      push_pct   = 50;
      while (sent < RANDOM_ITEMS) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 16);
            // lean towards filling or draining so both ends get hit often
            case ($urandom_range(0, 2))
               0: push_pct = 80;
               1: push_pct = 20;
               default: push_pct = 50;
            endcase
         end
         if (sent == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            await_drain();
         end
         if ($urandom_range(0, 99) < push_pct)
            op = mode_type'($urandom_range(0, 1));
         else
            op = mode_type'($urandom_range(2, 3));
         issue(op, pick_value());
         sent++;
         burst_left--;
      end
      req_valid <= 1'b0;
      await_drain();
      repeat (10) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("tb_circular_deque passed");
      else
         $display("tb_circular_deque failed");
      $finish;
   end

endmodule

/* files.f */
src/cd_pkg.sv
src/cd_ram.sv
src/cd_ctrl.sv
src/cd_datapath.sv
src/circular_deque.sv
tb/deque_checker.sv
tb/tb_circular_deque.sv
